// File: sv/pbkdf_pkg.sv
// Shared types, codes and constants for the PBKDF2 HMAC-SHA-256 derive unit.
// Holds the SHA-256 round constants and initial hash; depends on nothing.
`default_nettype none

package pbkdf_pkg;

  localparam int MAX_PASSWORD_BYTES = 64;
  localparam int MAX_SALT_BYTES = 64;
  localparam int MAX_KEY_BYTES = 64;
  localparam int DIGEST_BYTES = 32;
  localparam int SHA_BLOCK_BYTES = 64;
  localparam int SHA_ROUNDS = 64;
  localparam int BUF_AW = $clog2(MAX_PASSWORD_BYTES);
  localparam int SALT_ONE_BLOCK_MAX = SHA_BLOCK_BYTES - 4 - 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] ACT_PASSWORD = 2'd0;
  localparam logic [1:0] ACT_SALT = 2'd1;
  localparam logic [1:0] ACT_DERIVE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_PWD_FULL = 2'd1;
  localparam logic [1:0] ST_SALT_FULL = 2'd2;

  localparam logic CFG_ITER = 1'b0;
  localparam logic CFG_KEYLEN = 1'b1;
  localparam logic [31:0] CFG_ITER_RESET = 32'd1;
  localparam logic [6:0] CFG_KEYLEN_RESET = 7'd32;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       last;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [31:0] iteration_count;
    logic [6:0]  key_length;
  } cfg_t;

  typedef enum logic [2:0] {
    CMD_WR_PWD,
    CMD_WR_SALT,
    CMD_ERR_PWD,
    CMD_ERR_SALT,
    CMD_DERIVE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [BUF_AW-1:0] addr;
    logic [6:0]        pwd_count;
    logic [6:0]        salt_count;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_link_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FILL,
    BK_HASH,
    BK_WAIT,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [2:0] {
    MSG_IPAD,
    MSG_OPAD,
    MSG_SALT,
    MSG_CHAIN,
    MSG_OUTER
  } msg_kind_t;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [SHA_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [7:0] digest_byte(logic [255:0] v, logic [4:0] i);
    return v[{~i, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// File: sv/pbkdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for the password and salt buffers.
`default_nettype none

module pbkdf_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/pbkdf_sha.sv
// SHA-256 compression unit, one round per cycle over a 16-word schedule window.
// Depends on pbkdf_pkg for the round constants.
`default_nettype none

module pbkdf_sha import pbkdf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] h_in,
  input  logic [511:0] block,
  output logic         done,
  output logic [255:0] digest
);

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [31:0] hs [8];
  logic        run;
  logic [5:0]  rnd;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  always_comb begin
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[rnd] + w[0];
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];
    for (int i = 0; i < 8; i++) begin
      digest[(7 - i) * 32 +: 32] = hs[i] + v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      rnd <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        rnd <= '0;
      end else if (run) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'(SHA_ROUNDS - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= h_in[(7 - i) * 32 +: 32];
        hs[i] <= h_in[(7 - i) * 32 +: 32];
      end
      for (int i = 0; i < 16; i++) begin
        w[i] <= block[(15 - i) * 32 +: 32];
      end
    end else if (run) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= w_new;
    end
  end

endmodule

`default_nettype wire

// File: sv/pbkdf_front.sv
// Front end: takes input transactions, tracks buffer fill and flags overflow,
// and queues classified commands for the back end. Depends on pbkdf_pkg.
`default_nettype none

module pbkdf_front import pbkdf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  item_t     item,
  output logic      busy,
  output cmd_link_t link,
  input  logic      pop
);

  logic [6:0] pwd_count;
  logic [6:0] salt_count;
  cmd_t       q [QUEUE_DEPTH];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       accept;
  logic       push;
  cmd_t       ent;

  assign busy = (fill == 2'(QUEUE_DEPTH));
  assign accept = start && !busy;
  assign link.valid = (fill != 2'd0);
  assign link.cmd = q[rptr];

  always_comb begin
    ent.kind = CMD_WR_PWD;
    ent.data = item.data_byte;
    ent.addr = pwd_count[BUF_AW-1:0];
    ent.pwd_count = pwd_count;
    ent.salt_count = salt_count;
    push = 1'b0;
    if (accept) begin
      unique case (item.action)
        ACT_PASSWORD: begin
          push = 1'b1;
          ent.kind = (pwd_count >= 7'(MAX_PASSWORD_BYTES)) ? CMD_ERR_PWD : CMD_WR_PWD;
        end
        ACT_SALT: begin
          push = 1'b1;
          ent.addr = salt_count[BUF_AW-1:0];
          ent.kind = (salt_count >= 7'(MAX_SALT_BYTES)) ? CMD_ERR_SALT : CMD_WR_SALT;
        end
        ACT_DERIVE: begin
          push = 1'b1;
          ent.kind = CMD_DERIVE;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwd_count <= '0;
      salt_count <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
        if (ent.kind == CMD_WR_PWD) begin
          pwd_count <= pwd_count + 7'd1;
        end
        if (ent.kind == CMD_WR_SALT) begin
          salt_count <= salt_count + 7'd1;
        end
        if (ent.kind == CMD_DERIVE) begin
          pwd_count <= '0;
          salt_count <= '0;
        end
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= ent;
    end
  end

endmodule

`default_nettype wire

// File: sv/pbkdf_back.sv
// Back end: executes queued commands, owns the password and salt buffers,
// sequences the HMAC compressions and emits result bytes. Depends on
// pbkdf_pkg, pbkdf_ram and pbkdf_sha.
`default_nettype none

module pbkdf_back import pbkdf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_link_t link,
  output logic      pop,
  input  cfg_t      cfg,
  output logic      result_valid,
  output result_t   result
);

  bk_state_t         state;
  bk_state_t         state_next;
  msg_kind_t         phase;
  logic [6:0]        pc;
  logic [6:0]        sc;
  logic [6:0]        len;
  logic [6:0]        len_sat;
  logic [6:0]        c;
  logic              mblk;
  logic [1:0]        blk_idx;
  logic              first;
  logic [31:0]       rounds;
  logic [31:0]       rnext;
  logic              cont;
  logic [6:0]        produced;
  logic [4:0]        kbyte;
  logic              st_valid;
  logic              st_ram;
  logic [7:0]        st_byte;
  logic [7:0]        st_out;
  logic [511:0]      block;
  logic [255:0]      hinit;
  logic [255:0]      ipad_st;
  logic [255:0]      opad_st;
  logic [255:0]      inner;
  logic [255:0]      chain;
  logic [255:0]      acc;
  logic              sha_start;
  logic              sha_done;
  logic [255:0]      digest;
  logic              pwd_we;
  logic              salt_we;
  logic [7:0]        pwd_rdata;
  logic [7:0]        salt_rdata;
  logic              res_fire;
  result_t           res_next;
  logic              salt_two;
  logic [6:0]        pos;
  logic [6:0]        n;
  logic [6:0]        last_pos;
  logic [10:0]       bitlen;
  logic              gen_ram;
  logic [7:0]        gen_byte;

  pbkdf_ram #(.W(8), .D(MAX_PASSWORD_BYTES)) u_pwd_ram (
    .clk   (clk),
    .we    (pwd_we),
    .waddr (link.cmd.addr),
    .wdata (link.cmd.data),
    .raddr (c[BUF_AW-1:0]),
    .rdata (pwd_rdata)
  );

  pbkdf_ram #(.W(8), .D(MAX_SALT_BYTES)) u_salt_ram (
    .clk   (clk),
    .we    (salt_we),
    .waddr (link.cmd.addr),
    .wdata (link.cmd.data),
    .raddr (c[BUF_AW-1:0]),
    .rdata (salt_rdata)
  );

  pbkdf_sha u_sha (
    .clk    (clk),
    .rst    (rst),
    .start  (sha_start),
    .h_in   (hinit),
    .block  (block),
    .done   (sha_done),
    .digest (digest)
  );

  assign len_sat = (cfg.key_length > 7'(MAX_KEY_BYTES)) ? 7'(MAX_KEY_BYTES) : cfg.key_length;
  assign rnext = first ? 32'd1 : rounds + 32'd1;
  assign cont = (rnext < cfg.iteration_count);
  assign salt_two = (sc > 7'(SALT_ONE_BLOCK_MAX));
  assign st_out = (st_ram ? ((phase == MSG_SALT) ? salt_rdata : pwd_rdata) : 8'h00) ^ st_byte;

  // Message byte generator for the padded block being loaded.
  always_comb begin
    pos = {mblk, c[5:0]};
    n = (phase == MSG_SALT) ? sc + 7'd4 : 7'(DIGEST_BYTES);
    last_pos = (phase == MSG_SALT && salt_two) ? 7'(2 * SHA_BLOCK_BYTES - 1)
                                               : 7'(SHA_BLOCK_BYTES - 1);
    bitlen = {8'(SHA_BLOCK_BYTES) + {1'b0, n}, 3'b000};
    gen_ram = 1'b0;
    gen_byte = 8'h00;
    case (phase) inside
      MSG_IPAD, MSG_OPAD: begin
        gen_ram = (pos < pc);
        gen_byte = (phase == MSG_IPAD) ? IPAD_BYTE : OPAD_BYTE;
      end
      default: begin
        if (pos < n) begin
          if (phase == MSG_SALT) begin
            if (pos < sc) begin
              gen_ram = 1'b1;
            end else if (pos - sc == 7'd3) begin
              gen_byte = {6'b000000, blk_idx};
            end
          end else if (phase == MSG_CHAIN) begin
            gen_byte = digest_byte(chain, pos[4:0]);
          end else begin
            gen_byte = digest_byte(inner, pos[4:0]);
          end
        end else if (pos == n) begin
          gen_byte = PAD_MARK;
        end else if (pos == last_pos) begin
          gen_byte = bitlen[7:0];
        end else if (pos == last_pos - 7'd1) begin
          gen_byte = {5'b00000, bitlen[10:8]};
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    pwd_we = 1'b0;
    salt_we = 1'b0;
    sha_start = 1'b0;
    res_fire = 1'b0;
    res_next.key_byte = 8'h00;
    res_next.last = 1'b1;
    res_next.status = ST_PWD_FULL;
    unique case (state)
      BK_IDLE: begin
        if (link.valid) begin
          pop = 1'b1;
          unique case (link.cmd.kind)
            CMD_WR_PWD: pwd_we = 1'b1;
            CMD_WR_SALT: salt_we = 1'b1;
            CMD_ERR_PWD: res_fire = 1'b1;
            CMD_ERR_SALT: begin
              res_fire = 1'b1;
              res_next.status = ST_SALT_FULL;
            end
            CMD_DERIVE: begin
              if (len_sat != 7'd0) begin
                state_next = BK_FILL;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      BK_FILL: begin
        if (c == 7'(SHA_BLOCK_BYTES)) begin
          state_next = BK_HASH;
        end
      end
      BK_HASH: begin
        sha_start = 1'b1;
        state_next = BK_WAIT;
      end
      BK_WAIT: begin
        if (sha_done) begin
          state_next = (phase == MSG_OUTER && !cont) ? BK_EMIT : BK_FILL;
        end
      end
      BK_EMIT: begin
        res_fire = 1'b1;
        res_next.key_byte = digest_byte(acc, kbyte);
        res_next.last = (produced + 7'd1 == len);
        res_next.status = ST_OK;
        if (produced + 7'd1 == len) begin
          state_next = BK_IDLE;
        end else if (&kbyte) begin
          state_next = BK_FILL;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      result_valid <= 1'b0;
      st_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= res_fire;
      st_valid <= (state == BK_FILL) && (c < 7'(SHA_BLOCK_BYTES));
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      result <= res_next;
    end
    if (st_valid) begin
      block <= {block[503:0], st_out};
    end
    st_ram <= gen_ram;
    st_byte <= gen_byte;
    case (state)
      BK_IDLE: begin
        pc <= link.cmd.pwd_count;
        sc <= link.cmd.salt_count;
        len <= len_sat;
        phase <= MSG_IPAD;
        hinit <= SHA_IV;
        c <= '0;
        mblk <= 1'b0;
        blk_idx <= 2'd1;
        produced <= '0;
        kbyte <= '0;
      end
      BK_FILL: begin
        c <= (c == 7'(SHA_BLOCK_BYTES)) ? 7'd0 : c + 7'd1;
      end
      BK_WAIT: begin
        if (sha_done) begin
          case (phase)
            MSG_IPAD: begin
              ipad_st <= digest;
              phase <= MSG_OPAD;
              hinit <= SHA_IV;
            end
            MSG_OPAD: begin
              opad_st <= digest;
              phase <= MSG_SALT;
              hinit <= ipad_st;
              first <= 1'b1;
            end
            MSG_SALT: begin
              if (!mblk && salt_two) begin
                hinit <= digest;
                mblk <= 1'b1;
              end else begin
                inner <= digest;
                mblk <= 1'b0;
                phase <= MSG_OUTER;
                hinit <= opad_st;
              end
            end
            MSG_CHAIN: begin
              inner <= digest;
              phase <= MSG_OUTER;
              hinit <= opad_st;
            end
            default: begin
              chain <= digest;
              acc <= first ? digest : (acc ^ digest);
              rounds <= rnext;
              first <= 1'b0;
              phase <= MSG_CHAIN;
              hinit <= ipad_st;
            end
          endcase
        end
      end
      BK_EMIT: begin
        produced <= produced + 7'd1;
        kbyte <= kbyte + 5'd1;
        if (&kbyte) begin
          blk_idx <= blk_idx + 2'd1;
          phase <= MSG_SALT;
          hinit <= ipad_st;
          first <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sha_done |-> state == BK_WAIT)
    else $error("Compression finished outside the wait state.");
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    state == BK_EMIT |-> produced < len)
    else $error("Key byte emitted beyond the key length.");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == BK_FILL |-> c <= 7'(SHA_BLOCK_BYTES))
    else $error("Block fill counter overran the block.");
  a_ram_quiet: assert property (@(posedge clk) disable iff (rst)
    (pwd_we || salt_we) |-> state == BK_IDLE && !res_fire)
    else $error("Buffer written outside command dispatch.");
`endif

endmodule

`default_nettype wire

// File: sv/pbkdf2_hmac_sha256_derive_unit.sv
// Top level of the PBKDF2 HMAC-SHA-256 derive unit: configuration registers,
// front end with command queue, and back end. Depends on pbkdf_pkg,
// pbkdf_front and pbkdf_back.
//
//   Channel   Signals                                 Transaction
//   input     start, busy, item                       start high and busy low
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid and cfg_ready
//   result    result_valid, result                    result_valid high, one cycle
//
// The back end writes each password or salt byte to its buffer as it pops the command.
// A derive runs SHA-256 compressions (64 byte loads, 64 rounds and handoff each):
// two for the key pads, then per 32-byte block two or three plus two more per
// extra iteration, then one key byte per cycle while a 32-byte block is emitted.
// A two-entry command queue takes transactions while the back end works;
// busy is high while it is full. Reset is synchronous and clears control state.
`default_nettype none

module pbkdf2_hmac_sha256_derive_unit import pbkdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  item_t       item,
  output logic        busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output result_t     result
);

  cfg_t      cfg;
  cmd_link_t link;
  logic      pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.iteration_count <= CFG_ITER_RESET;
      cfg.key_length <= CFG_KEYLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ITER: cfg.iteration_count <= cfg_data;
        CFG_KEYLEN: cfg.key_length <= cfg_data[6:0];
        default: cfg.key_length <= cfg.key_length;
      endcase
    end
  end

  pbkdf_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .link  (link),
    .pop   (pop)
  );

  pbkdf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .link         (link),
    .pop          (pop),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire
